// ===== rtl/lpht_pkg.sv =====
// Shared constants, codes and interface types for the linear probe hash join table.
package lpht_pkg;

   // Storage geometry
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   // log2 of the largest power of two not above TABLE_DEPTH
   localparam int SLOT_W      = $clog2(TABLE_DEPTH + 1) - 1;

   // Field widths
   localparam int KEY_W       = 32;
   localparam int STORE_KEY_W = 31;
   localparam int WORD_W      = STORE_KEY_W + 1;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int ENT_W       = 13;
   localparam int CNT_W       = 32;
   localparam int CFG_W       = 4;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

   // Multiplicative hash; only the low SLOT_W bits of the product are ever used
   localparam logic [31:0]       HASH_MULT = 32'h9E37_79B1;
   localparam logic [SLOT_W-1:0] HASH_LOW  = HASH_MULT[SLOT_W-1:0];

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOP    = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSERTED = 3'd0,
      STAT_DUP      = 3'd1,
      STAT_HIT      = 3'd2,
      STAT_MISS     = 3'd3,
      STAT_REJECTED = 3'd4,
      STAT_FULL     = 3'd5,
      STAT_CLEARED  = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_LOAD,
      S_CHECK,
      S_CLEAR,
      S_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;  // capture request word
      logic load;    // start slot from registered hash
      logic check;   // compare slot read data, advance or finish
      logic sweep;   // write one zero word of the clearing pass
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic key_ok;      // request key is positive
      logic finish;      // probe chain ends at this slot
      logic sweep_done;  // clearing pass is at the last address
   } dp_status_type;

endpackage

// ===== rtl/lpht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lpht_datapath.sv =====
// Datapath: hash, slot walk, key store, counters and response registers.
module lpht_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lpht_pkg::dp_cmd_type          cmd,
   output lpht_pkg::dp_status_type       stat,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lpht_pkg::CFG_W-1:0]    csr_table_size_log2,
   input  logic [lpht_pkg::KIND_W-1:0]   req_kind,
   input  logic signed [lpht_pkg::KEY_W-1:0] req_key,
   input  logic                          req_promo_flag,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_promo_out,
   output logic [lpht_pkg::CNT_W-1:0]    rsp_probe_row,
   output logic [lpht_pkg::ENT_W-1:0]    rsp_entries,
   output logic [lpht_pkg::ENT_W-1:0]    rsp_promo_entries,
   output logic [lpht_pkg::CNT_W-1:0]    rsp_matches_res,
   output logic [lpht_pkg::CNT_W-1:0]    rsp_promo_matches
);
   import lpht_pkg::*;

   logic [CFG_W-1:0]       cfg_ff;
   logic [4:0]             eff_log2;
   logic [SLOT_W-1:0]      mask;

   logic [KIND_W-1:0]      kind_ff;
   logic [STORE_KEY_W-1:0] key_ff;
   logic                   flag_ff;
   logic [2*SLOT_W-1:0]    prod_full;
   logic [SLOT_W-1:0]      prod_ff;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      count_ff, count_in;
   status_type             status_ff, status_in;
   logic                   promo_out_ff;
   logic [CNT_W-1:0]       row_ff;

   logic [ENT_W-1:0]       ent_ff, pent_ff;
   logic [CNT_W-1:0]       match_ff, pmatch_ff, probe_ff;
   logic [ADDR_W-1:0]      sweep_ff;

   logic [WORD_W-1:0]      rd_word;
   logic [STORE_KEY_W-1:0] rd_key;
   logic                   rd_flag;
   logic                   slot_empty, slot_match, slot_last, finish;
   logic                   commit_insert, commit_hit, is_clear;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [WORD_W-1:0]      wr_data;

   // Configuration register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_table_size_log2;
      end
   end

   // Active size: zero acts as one, large values clip at the table capacity
   always_comb begin
      eff_log2 = {1'b0, cfg_ff};
      if (eff_log2 == 5'd0) begin
         eff_log2 = 5'd1;
      end
      if (eff_log2 > 5'(SLOT_W)) begin
         eff_log2 = 5'(SLOT_W);
      end
      for (int i = 0; i < SLOT_W; i++) begin
         mask[i] = (5'(i) < eff_log2);
      end
   end

   assign prod_full   = req_key[SLOT_W-1:0] * HASH_LOW;
   assign stat.key_ok = (req_key != '0) && !req_key[KEY_W-1];

   // Slot compare
   assign rd_key     = rd_word[WORD_W-1:1];
   assign rd_flag    = rd_word[0];
   assign slot_empty = (rd_key == '0);
   assign slot_match = (rd_key == key_ff);
   assign slot_last  = (count_ff == mask);
   assign finish     = slot_empty || slot_match || slot_last;
   assign stat.finish = finish;
   assign stat.sweep_done = (sweep_ff == ADDR_W'(TABLE_DEPTH - 1));

   assign commit_insert = cmd.check && (kind_ff == KIND_INSERT) && slot_empty;
   assign commit_hit    = cmd.check && (kind_ff == KIND_PROBE) && slot_match && !slot_empty;
   assign is_clear      = cmd.accept && (req_kind == KIND_CLEAR);

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (cmd.load) begin
         slot_in  = prod_ff & mask;
         count_in = '0;
      end else if (cmd.check && !finish) begin
         slot_in  = (slot_ff + 1'b1) & mask;
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      if (kind_ff == KIND_INSERT) begin
         if (slot_empty) begin
            status_in = STAT_INSERTED;
         end else if (slot_match) begin
            status_in = STAT_DUP;
         end else begin
            status_in = STAT_FULL;
         end
      end else begin
         status_in = (slot_match && !slot_empty) ? STAT_HIT : STAT_MISS;
      end
   end

   // Item payload and response registers
   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      count_ff <= count_in;
      if (cmd.accept) begin
         kind_ff      <= req_kind;
         key_ff       <= req_key[STORE_KEY_W-1:0];
         flag_ff      <= req_promo_flag;
         prod_ff      <= prod_full[SLOT_W-1:0];
         row_ff       <= (req_kind == KIND_PROBE) ? probe_ff : '0;
         promo_out_ff <= 1'b0;
         status_ff    <= (req_kind == KIND_CLEAR) ? STAT_CLEARED : STAT_REJECTED;
      end else if (cmd.check && finish) begin
         status_ff    <= status_in;
         promo_out_ff <= commit_hit && rd_flag;
      end
   end

   // Counters, all saturating
   always_ff @(posedge clock) begin
      if (reset || is_clear) begin
         ent_ff    <= '0;
         pent_ff   <= '0;
         match_ff  <= '0;
         pmatch_ff <= '0;
         probe_ff  <= '0;
      end else begin
         if (cmd.accept && (req_kind == KIND_PROBE) && (probe_ff != '1)) begin
            probe_ff <= probe_ff + 1'b1;
         end
         if (commit_insert && (ent_ff != '1)) begin
            ent_ff <= ent_ff + 1'b1;
         end
         if (commit_insert && flag_ff && (pent_ff != '1)) begin
            pent_ff <= pent_ff + 1'b1;
         end
         if (commit_hit && (match_ff != '1)) begin
            match_ff <= match_ff + 1'b1;
         end
         if (commit_hit && rd_flag && (pmatch_ff != '1)) begin
            pmatch_ff <= pmatch_ff + 1'b1;
         end
      end
   end

   // Clearing pass address
   always_ff @(posedge clock) begin
      if (reset || cmd.accept) begin
         sweep_ff <= '0;
      end else if (cmd.sweep && !stat.sweep_done) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end

   assign wr_en   = cmd.sweep || commit_insert;
   assign wr_addr = cmd.sweep ? sweep_ff : ADDR_W'(slot_ff);
   assign wr_data = cmd.sweep ? '0 : {key_ff, flag_ff};

   lpht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ADDR_W'(slot_in)),
      .rd_data (rd_word)
   );

   assign rsp_status        = status_ff;
   assign rsp_promo_out     = promo_out_ff;
   assign rsp_probe_row     = row_ff;
   assign rsp_entries       = ent_ff;
   assign rsp_promo_entries = pent_ff;
   assign rsp_matches_res   = match_ff;
   assign rsp_promo_matches = pmatch_ff;

endmodule

// ===== rtl/lpht_ctrl.sv =====
// Controller: sequences accept, slot walk, clearing pass and response.
module lpht_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lpht_pkg::KIND_W-1:0] req_kind,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lpht_pkg::dp_cmd_type        cmd,
   input  lpht_pkg::dp_status_type     stat
);
   import lpht_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_kind) inside
                  KIND_INSERT, KIND_PROBE: state_in = stat.key_ok ? S_LOAD : S_RESP;
                  KIND_CLEAR:              state_in = S_CLEAR;
                  default:                 state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.finish) begin
               state_in = S_RESP;
            end
         end
         S_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

endmodule

// ===== rtl/linear_probe_hash_join_table.sv =====
// Top level of the linear probe hash join table.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------------------------
//  csr     | in        | csr_valid/csr_ready  | table_size_log2
//  req     | in        | req_valid/req_ready  | kind, key, promo_flag
//  rsp     | out       | rsp_valid/rsp_ready  | status, promo_out, probe_row, counts
//
// One item at a time. Insert/probe: accept, then the LOAD state forms the start slot
// from the registered hash, then the CHECK state visits one slot per cycle (single read
// port of the key store), then the response word. Rejected key: accept, then the response.
// Clear: a zeroing pass over all 4096 store entries, then the response word.
// After reset the same pass runs with req_ready low; csr writes are taken.
// A stalled response holds the block; req_ready is low until the word is taken.
module linear_probe_hash_join_table (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lpht_pkg::CFG_W-1:0]    csr_table_size_log2,
   // request
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lpht_pkg::KIND_W-1:0]   req_kind,
   input  logic signed [lpht_pkg::KEY_W-1:0] req_key,
   input  logic                          req_promo_flag,
   // response
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_promo_out,
   output logic [lpht_pkg::CNT_W-1:0]    rsp_probe_row,
   output logic [lpht_pkg::ENT_W-1:0]    rsp_entries,
   output logic [lpht_pkg::ENT_W-1:0]    rsp_promo_entries,
   output logic [lpht_pkg::CNT_W-1:0]    rsp_matches_res,
   output logic [lpht_pkg::CNT_W-1:0]    rsp_promo_matches
);
   import lpht_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   // Sequencer: owns both handshakes toward the request and response sides
   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Hash, key store walk, counters; response fields come straight from its registers
   lpht_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_table_size_log2 (csr_table_size_log2),
      .req_kind            (req_kind),
      .req_key             (req_key),
      .req_promo_flag      (req_promo_flag),
      .rsp_status          (rsp_status),
      .rsp_promo_out       (rsp_promo_out),
      .rsp_probe_row       (rsp_probe_row),
      .rsp_entries         (rsp_entries),
      .rsp_promo_entries   (rsp_promo_entries),
      .rsp_matches_res     (rsp_matches_res),
      .rsp_promo_matches   (rsp_promo_matches)
   );

endmodule

// ===== rtl/lpht_checker.sv =====
// Port-level checks for the linear probe hash join table, bound to the top level.
module lpht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_promo_out,
   input logic [lpht_pkg::CNT_W-1:0]    rsp_probe_row,
   input logic [lpht_pkg::ENT_W-1:0]    rsp_entries,
   input logic [lpht_pkg::ENT_W-1:0]    rsp_promo_entries,
   input logic [lpht_pkg::CNT_W-1:0]    rsp_matches_res,
   input logic [lpht_pkg::CNT_W-1:0]    rsp_promo_matches
);
   import lpht_pkg::*;

   // Stalled response holds valid, status, probe row and entry count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_probe_row) && $stable(rsp_entries))
      else $error("response word changed while stalled");

   // One item in flight: no request taken while a response is pending
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted with response pending");

   // Clear reports all counts at zero
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_CLEARED) |->
         (rsp_entries == '0) && (rsp_promo_entries == '0) && (rsp_matches_res == '0)
         && (rsp_promo_matches == '0) && (rsp_probe_row == '0))
      else $error("clear response with nonzero counts");

   // Flag only shown on a hit
   a_flag_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_HIT) |-> !rsp_promo_out)
      else $error("promo_out set without a hit");

   // Flagged counts never exceed their totals
   a_promo_le: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_promo_entries <= rsp_entries)
         && (rsp_promo_matches <= rsp_matches_res))
      else $error("flagged count above total");

endmodule

bind linear_probe_hash_join_table lpht_checker u_lpht_checker (.*);
